// ===== rtl/cca_pkg.sv =====
// Shared widths, register indexes, operation codes and the code classifier
// for the coverage accumulator. No dependencies.
package cca_pkg;

  localparam int SEG_DEPTH_DEF = 4096;

  localparam int POS_W   = 32;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 16;
  localparam int CODE_W  = 8;
  localparam int IDX_W   = 12;
  localparam int COV_W   = 40;
  localparam int SLEN_W  = 13;
  localparam int STYLE_W = 2;
  localparam int MODE_W  = 2;
  localparam int REG_W   = 32;
  localparam int REGI_W  = 2;

  localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

  // item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPLY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // register indexes
  localparam logic [REGI_W-1:0] REG_SEG_START = 2'd0;
  localparam logic [REGI_W-1:0] REG_SEG_LEN   = 2'd1;
  localparam logic [REGI_W-1:0] REG_SPLIT     = 2'd2;
  localparam logic [REGI_W-1:0] REG_STYLE     = 2'd3;

  // coverage styles
  localparam logic [STYLE_W-1:0] STYLE_SPAN  = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_START = 2'd1;

  // operation characters
  localparam logic [CODE_W-1:0] CODE_SC_A = 8'h61;  // 'a'
  localparam logic [CODE_W-1:0] CODE_SC_T = 8'h74;  // 't'
  localparam logic [CODE_W-1:0] CODE_SC_G = 8'h67;  // 'g'
  localparam logic [CODE_W-1:0] CODE_SC_C = 8'h63;  // 'c'
  localparam logic [CODE_W-1:0] CODE_SC_N = 8'h6E;  // 'n'
  localparam logic [CODE_W-1:0] CODE_QUAL_LO = 8'd123;  // 33 + 90
  localparam logic [CODE_W-1:0] CODE_QUAL_HI = 8'd163;  // 73 + 90
  localparam logic [CODE_W-1:0] CODE_DEL    = 8'h44;  // 'D'
  localparam logic [CODE_W-1:0] CODE_INTRON = 8'h4E;  // 'N'
  localparam logic [CODE_W-1:0] CODE_INS_LO = 8'h21;  // '!'
  localparam logic [CODE_W-1:0] CODE_INS_HI = 8'h25;  // '%'
  localparam logic [CODE_W-1:0] CODE_MM_LO  = 8'h26;  // '&'
  localparam logic [CODE_W-1:0] CODE_MM_HI  = 8'h2A;  // '*'

  // operation classes
  typedef logic [1:0] op_class_t;
  localparam op_class_t OPC_SKIP   = 2'd0;
  localparam op_class_t OPC_ADV    = 2'd1;
  localparam op_class_t OPC_COVER  = 2'd2;
  localparam op_class_t OPC_SINGLE = 2'd3;

  // Sort one operation code into its class
  function automatic op_class_t op_class(input logic [CODE_W-1:0] code, input logic split);
    op_class_t cls;
    cls = OPC_COVER;
    case (code) inside
      CODE_SC_A, CODE_SC_T, CODE_SC_G, CODE_SC_C, CODE_SC_N: cls = OPC_SKIP;
      [CODE_QUAL_LO:CODE_QUAL_HI]:                           cls = OPC_SKIP;
      [CODE_INS_LO:CODE_INS_HI]:                             cls = OPC_SKIP;
      [CODE_MM_LO:CODE_MM_HI]:                               cls = OPC_SINGLE;
      CODE_DEL:                                              cls = OPC_ADV;
      CODE_INTRON:                                           cls = split ? OPC_ADV : OPC_COVER;
      default:                                               cls = OPC_COVER;
    endcase
    return cls;
  endfunction

  // Result of the shared arithmetic unit
  typedef struct packed {
    logic             in_range;
    logic [32:0]      rel;
    logic [COV_W-1:0] sum;
  } arith_res_t;

endpackage

// ===== rtl/cca_if.sv =====
// Valid/ready channels of the coverage accumulator: operation items in,
// result beats out. Depends on cca_pkg.
interface cca_in_if;
  logic                          valid;
  logic                          ready;
  logic [cca_pkg::MODE_W-1:0]    mode;
  logic [cca_pkg::POS_W-1:0]     read_position;
  logic                          first_op;
  logic [cca_pkg::CODE_W-1:0]    op_code;
  logic [cca_pkg::LEN_W-1:0]     op_length;
  logic [cca_pkg::CNT_W-1:0]     read_count;
  logic [cca_pkg::IDX_W-1:0]     entry_index;

  modport source (output valid, mode, read_position, first_op, op_code, op_length,
                  read_count, entry_index, input ready);
  modport sink   (input valid, mode, read_position, first_op, op_code, op_length,
                  read_count, entry_index, output ready);
endinterface

interface cca_out_if;
  logic                        valid;
  logic                        ready;
  logic [cca_pkg::COV_W-1:0]   coverage;
  logic                        status;

  modport source (output valid, coverage, status, input ready);
  modport sink   (input valid, coverage, status, output ready);
endinterface

// ===== rtl/cigar_coverage_accumulator_unit.sv =====
// Top level of the coverage accumulator: configuration registers and the
// sequencer around the shared arithmetic unit and the counter memory.
// Depends on cca_pkg, cca_if, cca_store and cca_arith.
//
// Usage: items arrive on in_ch (valid/ready), one result beat per item leaves
// on out_ch. Configuration is written on wr_en/wr_index/wr_data; the user
// must write it only while idle, and the block itself does not enforce this.
// Apply items walk their span one base at a time: each base passes a check
// state (address and bounds check with memory read), then an update state
// (saturating add and write back through the memory port). Skipped and
// offset-only codes and read items go straight to the done state. A clear
// item sweeps the memory, one entry a cycle. After reset the same sweep runs
// before the first item is accepted; configuration writes are taken during
// it. The result sits in an output register: the next item is accepted while
// it waits, but a finished item holds the sequencer until the receiver takes
// the earlier beat.
module cigar_coverage_accumulator_unit #(
  parameter int SEG_DEPTH = cca_pkg::SEG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  cca_in_if.sink                      in_ch,
  cca_out_if.source                   out_ch,
  input  logic                        wr_en,
  input  logic [cca_pkg::REGI_W-1:0]  wr_index,
  input  logic [cca_pkg::REG_W-1:0]   wr_data
);

  localparam int AW    = $clog2(SEG_DEPTH);
  localparam int LIM_W = $clog2(SEG_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SEG_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // configuration
  logic [31:0]                       seg_start;
  logic [cca_pkg::SLEN_W-1:0]        seg_len;
  logic                              split;
  logic [cca_pkg::STYLE_W-1:0]       style;

  // sequencer state
  logic [2:0]                        state;
  logic [AW-1:0]                     clr_addr;
  logic                              clr_reply;
  logic signed [32:0]                base;
  logic [31:0]                       offset;
  logic [cca_pkg::LEN_W-1:0]         remain;
  logic                              use_off;
  logic [cca_pkg::CNT_W-1:0]         count;
  logic [AW-1:0]                     upd_addr;
  logic                              take_mem;
  logic                              res_status;

  logic                              accept;
  logic                              out_free;
  cca_pkg::op_class_t                cls;
  logic [cca_pkg::LEN_W-1:0]         eff_len;
  logic [31:0]                       off_start;
  logic [31:0]                       lim32;
  logic [LIM_W-1:0]                  limit;
  logic [31:0]                       idx32;
  cca_pkg::arith_res_t               ares;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [cca_pkg::COV_W-1:0]         mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic [cca_pkg::COV_W-1:0]         mem_rdata;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  // decode the incoming operation
  assign cls       = cca_pkg::op_class(in_ch.op_code, split);
  assign eff_len   = (cls == cca_pkg::OPC_SINGLE) ? cca_pkg::LEN_W'(1) : in_ch.op_length;
  assign off_start = in_ch.first_op ? 32'd0 : offset;
  assign idx32     = 32'(in_ch.entry_index);

  // effective segment limit, capped at the store depth
  assign lim32 = (32'(seg_len) > 32'(SEG_DEPTH)) ? 32'(SEG_DEPTH) : 32'(seg_len);
  assign limit = lim32[LIM_W-1:0];

  cca_arith #(.LIM_W(LIM_W)) u_arith (
    .base   (base),
    .offset (use_off ? offset : 32'd0),
    .limit  (limit),
    .cur    (mem_rdata),
    .count  (count),
    .res    (ares)
  );

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = upd_addr;
    mem_wdata = ares.sum;
    mem_re    = 1'b0;
    mem_raddr = ares.rel[AW-1:0];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_UPDATE) begin
      mem_we = 1'b1;
    end else if (state == S_CHECK) begin
      mem_re = ares.in_range;
    end else if (accept && in_ch.mode == cca_pkg::MODE_READ) begin
      mem_re    = idx32 < 32'(SEG_DEPTH);
      mem_raddr = idx32[AW-1:0];
    end
  end

  cca_store #(.DEPTH(SEG_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start <= '0;
      seg_len   <= cca_pkg::SLEN_W'(4096);
      split     <= 1'b0;
      style     <= cca_pkg::STYLE_SPAN;
    end else if (wr_en) begin
      unique case (wr_index)
        cca_pkg::REG_SEG_START: seg_start <= wr_data;
        cca_pkg::REG_SEG_LEN:   seg_len   <= wr_data[cca_pkg::SLEN_W-1:0];
        cca_pkg::REG_SPLIT:     split     <= wr_data[0];
        cca_pkg::REG_STYLE:     style     <= wr_data[cca_pkg::STYLE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      offset    <= '0;
      use_off   <= 1'b0;
      take_mem  <= 1'b0;
      res_status <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // drop a taken beat unless a finished item reloads it below
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            take_mem   <= 1'b0;
            res_status <= 1'b0;
            base       <= $signed({1'b0, in_ch.read_position}) - $signed({1'b0, seg_start});
            count      <= in_ch.read_count;
            state      <= S_DONE;
            if (in_ch.mode == cca_pkg::MODE_CLEAR) begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else if (in_ch.mode == cca_pkg::MODE_READ) begin
              take_mem <= idx32 < 32'(SEG_DEPTH);
            end else if (in_ch.mode == cca_pkg::MODE_APPLY) begin
              offset <= off_start;
              if (cls == cca_pkg::OPC_ADV) begin
                offset <= off_start + 32'(in_ch.op_length);
              end else if (cls != cca_pkg::OPC_SKIP && eff_len != '0) begin
                if (style == cca_pkg::STYLE_SPAN) begin
                  remain  <= eff_len;
                  use_off <= 1'b1;
                  state   <= S_CHECK;
                end else if (style == cca_pkg::STYLE_START) begin
                  remain  <= cca_pkg::LEN_W'(1);
                  use_off <= 1'b0;
                  state   <= S_CHECK;
                end
              end
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_CHECK: begin
          // drop the rest of the operation at the first base outside
          upd_addr <= ares.rel[AW-1:0];
          if (ares.in_range) begin
            state <= S_UPDATE;
          end else begin
            res_status <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_UPDATE: begin
          if (use_off) begin
            offset <= offset + 32'd1;
          end
          remain <= remain - cca_pkg::LEN_W'(1);
          state  <= (remain == cca_pkg::LEN_W'(1)) ? S_DONE : S_CHECK;
        end
        S_DONE: begin
          // hold until the output register is free, then load the beat
          if (out_free) begin
            out_ch.valid    <= 1'b1;
            out_ch.coverage <= take_mem ? mem_rdata : '0;
            out_ch.status   <= res_status;
            clr_reply       <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cca_store.sv =====
// Coverage counter memory: one write port, one read port with registered data.
// Depends on cca_pkg.
module cca_store #(
  parameter int DEPTH = cca_pkg::SEG_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cca_pkg::COV_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [cca_pkg::COV_W-1:0] rdata
);

  logic [cca_pkg::COV_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cca_arith.sv =====
// Shared arithmetic unit: segment-relative address with bounds check, and
// saturating counter add. Depends on cca_pkg.
module cca_arith #(
  parameter int LIM_W = 13
) (
  input  logic signed [32:0]              base,
  input  logic [31:0]                     offset,
  input  logic [LIM_W-1:0]                limit,
  input  logic [cca_pkg::COV_W-1:0]       cur,
  input  logic [cca_pkg::CNT_W-1:0]       count,
  output cca_pkg::arith_res_t             res
);

  logic signed [33:0]          rel;
  logic [cca_pkg::COV_W:0]     sum;

  // relative position and bounds check
  assign rel = 34'(base) + $signed({2'b00, offset});
  assign res.rel = rel[32:0];
  assign res.in_range = !rel[33] && (rel[32:0] < 33'(limit));

  // saturate at the top of the counter range
  assign sum = {1'b0, cur} + (cca_pkg::COV_W + 1)'(count);
  assign res.sum = sum[cca_pkg::COV_W] ? cca_pkg::COV_MAX : sum[cca_pkg::COV_W-1:0];

endmodule
